// ----- hdl/puag_pkg.sv -----
// Shared types and constants of the polar unwrap address generator.
package puag_pkg;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_CENTRE_PACKED = 3'd0,
      CSR_MIN_DIAMETER  = 3'd1,
      CSR_MAX_DIAMETER  = 3'd2,
      CSR_ANGLE_OFFSET  = 3'd3,
      CSR_ASPECT        = 3'd4,
      CSR_OUT_WIDTH     = 3'd5,
      CSR_SOURCE_COLS   = 3'd6,
      CSR_SOURCE_ROWS   = 3'd7
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Field widths.
   localparam int RING_W   = 10;
   localparam int COL_W    = 12;
   localparam int COORD_W  = 12;
   localparam int INDEX_W  = 24;
   localparam int DIAM_W   = 17;
   localparam int PHASE_W  = 16;
   localparam int DIM_W    = 13;

   // Reset values of the configuration registers.
   localparam logic [31:0]     RST_CENTRE_PACKED = 32'h8000_8000;
   localparam logic [DIAM_W-1:0] RST_MIN_DIAMETER = 17'd16384;
   localparam logic [DIAM_W-1:0] RST_MAX_DIAMETER = 17'd65536;
   localparam logic [15:0]     RST_ANGLE_OFFSET  = 16'd0;
   localparam logic [15:0]     RST_ASPECT        = 16'd4096;
   localparam logic [DIM_W-1:0] RST_OUT_WIDTH    = 13'd4096;
   localparam logic [DIM_W-1:0] RST_SOURCE_COLS  = 13'd1920;
   localparam logic [DIM_W-1:0] RST_SOURCE_ROWS  = 13'd1080;

   // 1/(2*pi) in Q0.32 and pi in Q2.30.
   localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
   localparam longint      PI_Q30         = 64'd3373259426;

   // A quarter turn of phase.
   localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'd16384;

   // Pipelined divider: one quotient bit per stage.
   localparam int DIV_STAGES = 28;
   localparam int DIV_DEN_W  = 13;

   // One sine table lookup: magnitude in Q0.16 and sign.
   typedef struct packed {
      logic        neg;
      logic [15:0] mag;
   } sine_sample_type;

endpackage

// ----- hdl/puag_channels.sv -----
// Handshake channels of the polar unwrap address generator.
interface puag_req_if;
   import puag_pkg::*;
   logic               valid;
   logic               ready;
   logic [RING_W-1:0]  ring_index;
   logic [COL_W-1:0]   out_col;
   modport source (output valid, ring_index, out_col, input ready);
   modport sink   (input valid, ring_index, out_col, output ready);
endinterface

interface puag_rsp_if;
   import puag_pkg::*;
   logic                valid;
   logic                ready;
   logic [COORD_W-1:0]  src_x;
   logic [COORD_W-1:0]  src_y;
   logic [INDEX_W-1:0]  src_index;
   logic                out_of_range;
   modport source (output valid, src_x, src_y, src_index, out_of_range, input ready);
   modport sink   (input valid, src_x, src_y, src_index, out_of_range, output ready);
endinterface

// ----- hdl/puag_div_pipe.sv -----
// Two-lane pipelined restoring divider, one quotient bit per stage.
module puag_div_pipe import puag_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [DIV_STAGES-1:0] num_a,
   input  logic [DIV_STAGES-1:0] num_b,
   input  logic [DIV_DEN_W-1:0]  den_a,
   input  logic [DIV_DEN_W-1:0]  den_b,
   output logic                  out_valid,
   output logic [15:0]           quo_a,
   output logic [15:0]           quo_b
);

   logic [DIV_DEN_W-1:0]  rem_a_ff [DIV_STAGES+1];
   logic [DIV_DEN_W-1:0]  rem_b_ff [DIV_STAGES+1];
   logic [DIV_STAGES-1:0] num_a_ff [DIV_STAGES+1];
   logic [DIV_STAGES-1:0] num_b_ff [DIV_STAGES+1];
   logic                  valid_ff [DIV_STAGES+1];

   // Entry point of the chain is the unregistered input.
   assign rem_a_ff[0] = '0;
   assign rem_b_ff[0] = '0;
   assign num_a_ff[0] = num_a;
   assign num_b_ff[0] = num_b;
   assign valid_ff[0] = in_valid;

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      logic [DIV_DEN_W:0]     rem2_a, rem2_b;
      logic                   ge_a, ge_b;
      logic [DIV_DEN_W-1:0]   rem_a_in, rem_b_in;
      logic [DIV_STAGES-1:0]  num_a_in, num_b_in;

      always_comb begin
         rem2_a   = {rem_a_ff[i], num_a_ff[i][DIV_STAGES-1]};
         rem2_b   = {rem_b_ff[i], num_b_ff[i][DIV_STAGES-1]};
         ge_a     = rem2_a >= {1'b0, den_a};
         ge_b     = rem2_b >= {1'b0, den_b};
         rem_a_in = ge_a ? DIV_DEN_W'(rem2_a - {1'b0, den_a}) : DIV_DEN_W'(rem2_a);
         rem_b_in = ge_b ? DIV_DEN_W'(rem2_b - {1'b0, den_b}) : DIV_DEN_W'(rem2_b);
         num_a_in = {num_a_ff[i][DIV_STAGES-2:0], ge_a};
         num_b_in = {num_b_ff[i][DIV_STAGES-2:0], ge_b};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (en) begin
            rem_a_ff[i+1] <= rem_a_in;
            rem_b_ff[i+1] <= rem_b_in;
            num_a_ff[i+1] <= num_a_in;
            num_b_ff[i+1] <= num_b_in;
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES];
   assign quo_a     = num_a_ff[DIV_STAGES][15:0];
   assign quo_b     = num_b_ff[DIV_STAGES][15:0];

endmodule

// ----- hdl/puag_sine_rom.sv -----
// Quarter-wave sine table with two registered read ports.
module puag_sine_rom import puag_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  logic                clock,
   input  logic                en,
   input  logic [PHASE_W-1:0]  phase_s,
   input  logic [PHASE_W-1:0]  phase_c,
   output sine_sample_type     sample_s,
   output sine_sample_type     sample_c
);

   localparam int KW = $clog2(DEPTH);
   localparam int PW = 14 + KW + 1;

   logic [15:0]     rom [DEPTH];
   logic [KW-1:0]   idx_s, idx_c;
   sine_sample_type sample_s_ff, sample_c_ff;

   // Entry k is sin at the centre of its slot, 11th-order Taylor series in Q30.
   for (genvar k = 0; k < DEPTH; k++) begin : g_tab
      localparam longint X  = (PI_Q30 * (2 * k + 1)) / (4 * DEPTH);
      localparam longint A1 = (X * X) >> 30;
      localparam longint T1 = ((A1 * X) >> 30) / 6;
      localparam longint A2 = (T1 * X) >> 30;
      localparam longint T2 = ((A2 * X) >> 30) / 20;
      localparam longint A3 = (T2 * X) >> 30;
      localparam longint T3 = ((A3 * X) >> 30) / 42;
      localparam longint A4 = (T3 * X) >> 30;
      localparam longint T4 = ((A4 * X) >> 30) / 72;
      localparam longint A5 = (T4 * X) >> 30;
      localparam longint T5 = ((A5 * X) >> 30) / 110;
      localparam longint S  = X - T1 + T2 - T3 + T4 - T5;
      localparam longint SC = (S < 0) ? 0 : S;
      localparam longint V  = (SC + 8192) >> 14;
      localparam longint E  = (V > 65535) ? 65535 : V;
      assign rom[k] = 16'(E);
   end

   function automatic logic [KW-1:0] table_index(input logic [PHASE_W-1:0] p);
      logic [PW-1:0] prod;
      logic [KW-1:0] k;
      prod = PW'(p[13:0]) * PW'(DEPTH);
      k    = KW'(prod >> 14);
      if (p[14]) begin
         k = KW'(DEPTH - 1) - k;
      end
      return k;
   endfunction

   assign idx_s = table_index(phase_s);
   assign idx_c = table_index(phase_c);

   always_ff @(posedge clock) begin
      if (en) begin
         sample_s_ff.mag <= rom[idx_s];
         sample_s_ff.neg <= phase_s[15];
         sample_c_ff.mag <= rom[idx_c];
         sample_c_ff.neg <= phase_c[15];
      end
   end

   assign sample_s = sample_s_ff;
   assign sample_c = sample_c_ff;

endmodule

// ----- hdl/polar_unwrap_address_generator.sv -----
// Polar unwrap address generator: top level.
// Maps each (ring_index, out_col) transaction of a panoramic output strip to the source pixel
// of a circular camera image that it samples, returning the clamped column and row, the
// linear index row * cols + column (24 bits) and a flag set when the point fell outside the
// source and was clamped. One transaction is accepted every clock cycle while the result
// side does not stall, and each produces exactly one result transaction; the path holds 37
// register stages. They are the input register and the 28-stage pipelined divider, which
// forms both the radial fraction (ring / rings-per-strip) and the column's fraction of a
// full turn one quotient bit per stage, followed by eight stages of sine lookup,
// multiplication and clamping. A stall on the result side freezes the whole pipeline, and
// req_port.ready then falls. The user must write the configuration registers through the
// csr_ port only while no transaction is in flight; the block itself does not enforce this,
// and the values derived from them pass through a further register before they take effect.
module polar_unwrap_address_generator import puag_pkg::*; #(
   parameter int MAX_WIDTH        = 4096,
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int MAX_SOURCE_DIM   = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   puag_req_if.sink               req_port,
   puag_rsp_if.source             rsp_port,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // ---------------------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------------------
   logic [31:0]        cfg_centre_ff;
   logic [DIAM_W-1:0]  cfg_min_diam_ff, cfg_max_diam_ff;
   logic [15:0]        cfg_offset_ff, cfg_aspect_ff;
   logic [DIM_W-1:0]   cfg_out_width_ff, cfg_cols_ff, cfg_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_centre_ff    <= RST_CENTRE_PACKED;
         cfg_min_diam_ff  <= RST_MIN_DIAMETER;
         cfg_max_diam_ff  <= RST_MAX_DIAMETER;
         cfg_offset_ff    <= RST_ANGLE_OFFSET;
         cfg_aspect_ff    <= RST_ASPECT;
         cfg_out_width_ff <= RST_OUT_WIDTH;
         cfg_cols_ff      <= RST_SOURCE_COLS;
         cfg_rows_ff      <= RST_SOURCE_ROWS;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_CENTRE_PACKED: cfg_centre_ff    <= csr_write_data;
            CSR_MIN_DIAMETER:  cfg_min_diam_ff  <= csr_write_data[DIAM_W-1:0];
            CSR_MAX_DIAMETER:  cfg_max_diam_ff  <= csr_write_data[DIAM_W-1:0];
            CSR_ANGLE_OFFSET:  cfg_offset_ff    <= csr_write_data[15:0];
            CSR_ASPECT:        cfg_aspect_ff    <= csr_write_data[15:0];
            CSR_OUT_WIDTH:     cfg_out_width_ff <= csr_write_data[DIM_W-1:0];
            CSR_SOURCE_COLS:   cfg_cols_ff      <= csr_write_data[DIM_W-1:0];
            CSR_SOURCE_ROWS:   cfg_rows_ff      <= csr_write_data[DIM_W-1:0];
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Values derived from the configuration. They are registered, so they settle after the
   // configuration register itself; a transaction only reaches them after the input register.
   // ---------------------------------------------------------------------------------
   logic [DIM_W-1:0]      w_in, w_ff;
   logic [42:0]           h_prod;
   logic [10:0]           h_in, h_ff;
   logic [DIM_W-1:0]      cols_lim, rows_lim, cols_in, rows_in, cols_ff, rows_ff;

   always_comb begin
      // Width of the strip is capped, and sets the ring count floor(W / 2pi).
      w_in     = (int'(cfg_out_width_ff) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cfg_out_width_ff;
      h_prod   = 43'(w_in) * 43'(INV_TWO_PI_Q32);
      h_in     = h_prod[42:32];
      // Source size is capped at the largest supported dimension, and zero acts as one.
      cols_lim = (int'(cfg_cols_ff) > MAX_SOURCE_DIM) ? DIM_W'(MAX_SOURCE_DIM) : cfg_cols_ff;
      rows_lim = (int'(cfg_rows_ff) > MAX_SOURCE_DIM) ? DIM_W'(MAX_SOURCE_DIM) : cfg_rows_ff;
      cols_in  = (cols_lim == '0) ? DIM_W'(1) : cols_lim;
      rows_in  = (rows_lim == '0) ? DIM_W'(1) : rows_lim;
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      h_ff    <= h_in;
      cols_ff <= cols_in;
      rows_ff <= rows_in;
   end

   // ---------------------------------------------------------------------------------
   // Pipeline control. Every stage advances together unless the output register holds
   // a result that the sink has not taken.
   // ---------------------------------------------------------------------------------
   logic en;
   logic v0_ff, va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff, vh_ff;
   logic div_valid;

   assign en             = !vh_ff || rsp_port.ready;
   assign req_port.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
         vh_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_port.valid;
         va_ff <= div_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
         vg_ff <= vf_ff;
         vh_ff <= vg_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Input register.
   // ---------------------------------------------------------------------------------
   logic [RING_W-1:0] ring_ff;
   logic [COL_W-1:0]  col_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ring_ff <= req_port.ring_index;
         col_ff  <= req_port.out_col;
      end
   end

   // ---------------------------------------------------------------------------------
   // Divider: radial fraction f = (ring << 16) / H and column phase (col << 16) / W.
   // A ring beyond the strip is treated as the outermost ring.
   // ---------------------------------------------------------------------------------
   logic [RING_W-1:0]     ring_clamped;
   logic [DIV_STAGES-1:0] num_ring, num_col;
   logic [15:0]           quo_ring, quo_col;

   always_comb begin
      ring_clamped = ({1'b0, ring_ff} >= h_ff) ? RING_W'(h_ff - 11'd1) : ring_ff;
      num_ring     = DIV_STAGES'({ring_clamped, 16'b0});
      num_col      = DIV_STAGES'({col_ff, 16'b0});
   end

   puag_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v0_ff),
      .num_a     (num_ring),
      .num_b     (num_col),
      .den_a     (DIV_DEN_W'(h_ff)),
      .den_b     (w_ff),
      .out_valid (div_valid),
      .quo_a     (quo_ring),
      .quo_b     (quo_col)
   );

   // ---------------------------------------------------------------------------------
   // Stage a: phase, and the two partial products of the radius interpolation.
   // A strip of no rings uses the inner radius; zero width adds no column phase.
   // ---------------------------------------------------------------------------------
   logic [15:0]        f_sel, step_sel;
   logic [PHASE_W-1:0] phase_in, phase_ff;
   logic [33:0]        m1_in, m1_ff;
   logic [32:0]        m2_in, m2_ff;

   always_comb begin
      f_sel    = (h_ff == '0) ? 16'd0 : quo_ring;
      step_sel = (w_ff == '0) ? 16'd0 : quo_col;
      phase_in = step_sel + cfg_offset_ff;
      m1_in    = 34'(cfg_min_diam_ff) * (34'd65536 - 34'(f_sel));
      m2_in    = 33'(cfg_max_diam_ff) * 33'(f_sel);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phase_ff <= phase_in;
         m1_ff    <= m1_in;
         m2_ff    <= m2_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage b: sine and cosine lookups, radius in Q0.16 (half the interpolated diameter).
   // ---------------------------------------------------------------------------------
   sine_sample_type sample_s, sample_c;
   logic [34:0]     a_sum;
   logic [15:0]     radius_ff;

   puag_sine_rom #(
      .DEPTH (SINE_TABLE_DEPTH)
   ) u_sine (
      .clock    (clock),
      .en       (en),
      .phase_s  (phase_ff),
      .phase_c  (phase_ff + QUARTER_TURN),
      .sample_s (sample_s),
      .sample_c (sample_c)
   );

   assign a_sum = 35'(m1_ff) + 35'(m2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         radius_ff <= a_sum[32:17];
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage c: magnitudes scaled by the radius.
   // ---------------------------------------------------------------------------------
   logic [31:0] t_s_ff, t_c_ff;
   logic        neg_s_c_ff, neg_c_c_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t_s_ff     <= 32'(sample_s.mag) * 32'(radius_ff);
         t_c_ff     <= 32'(sample_c.mag) * 32'(radius_ff);
         neg_s_c_ff <= sample_s.neg;
         neg_c_c_ff <= sample_c.neg;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage d: aspect gain on the sine axis; V' = vc - floor(C * R / 2^16).
   // ---------------------------------------------------------------------------------
   logic signed [32:0] c_prod;
   logic signed [16:0] c_shift;
   logic signed [18:0] vp_in, vp_ff;
   logic [47:0]        ts_ff;
   logic               neg_s_d_ff;

   always_comb begin
      c_prod  = neg_c_c_ff ? -$signed({1'b0, t_c_ff}) : $signed({1'b0, t_c_ff});
      c_shift = c_prod[32:16];
      vp_in   = $signed({3'b000, cfg_centre_ff[15:0]}) - {{2{c_shift[16]}}, c_shift};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ts_ff      <= 48'(cfg_aspect_ff) * 48'(t_s_ff);
         neg_s_d_ff <= neg_s_c_ff;
         vp_ff      <= vp_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage e: U = uc + floor(aspect * S * R / 2^28), kept as 65536 - U for the row;
   // column product V' * cols.
   // ---------------------------------------------------------------------------------
   logic signed [48:0] s_prod;
   logic signed [20:0] s_shift;
   logic signed [22:0] u_val, ym_in, ym_ff;
   logic signed [32:0] xp_in, xp_ff;

   always_comb begin
      s_prod  = neg_s_d_ff ? -$signed({1'b0, ts_ff}) : $signed({1'b0, ts_ff});
      s_shift = s_prod[48:28];
      u_val   = $signed({7'b0, cfg_centre_ff[31:16]}) + {{2{s_shift[20]}}, s_shift};
      ym_in   = $signed(23'd65536) - u_val;
      xp_in   = vp_ff * $signed({1'b0, cols_ff});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ym_ff <= ym_in;
         xp_ff <= xp_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage f: row product, column coordinate (arithmetic shift is a floor).
   // ---------------------------------------------------------------------------------
   logic signed [36:0] yp_in, yp_ff;
   logic signed [16:0] x_ff;

   assign yp_in = ym_ff * $signed({1'b0, rows_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         yp_ff <= yp_in;
         x_ff  <= xp_ff[32:16];
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage g: clamp both coordinates to the source image and flag the clamp.
   // ---------------------------------------------------------------------------------
   logic signed [20:0] y_val;
   logic [DIM_W-1:0]   x_max, y_max, xc_in, yc_in, xc_ff, yc_ff;
   logic               x_lo, x_hi, y_lo, y_hi, oor_g_ff;

   always_comb begin
      y_val = yp_ff[36:16];
      x_max = cols_ff - DIM_W'(1);
      y_max = rows_ff - DIM_W'(1);
      x_lo  = x_ff[16];
      x_hi  = !x_ff[16] && (x_ff[15:0] > 16'(x_max));
      y_lo  = y_val[20];
      y_hi  = !y_val[20] && (y_val[19:0] > 20'(y_max));
      xc_in = x_lo ? '0 : (x_hi ? x_max : x_ff[DIM_W-1:0]);
      yc_in = y_lo ? '0 : (y_hi ? y_max : y_val[DIM_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xc_ff    <= xc_in;
         yc_ff    <= yc_in;
         oor_g_ff <= x_lo || x_hi || y_lo || y_hi;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage h: linear index and the output register.
   // ---------------------------------------------------------------------------------
   logic [25:0]         idx_full;
   logic [COORD_W-1:0]  src_x_ff, src_y_ff;
   logic [INDEX_W-1:0]  src_index_ff;
   logic                oor_ff;

   assign idx_full = 26'(yc_ff) * 26'(cols_ff) + 26'(xc_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         src_x_ff     <= xc_ff[COORD_W-1:0];
         src_y_ff     <= yc_ff[COORD_W-1:0];
         src_index_ff <= idx_full[INDEX_W-1:0];
         oor_ff       <= oor_g_ff;
      end
   end

   assign rsp_port.valid        = vh_ff;
   assign rsp_port.src_x        = src_x_ff;
   assign rsp_port.src_y        = src_y_ff;
   assign rsp_port.src_index    = src_index_ff;
   assign rsp_port.out_of_range = oor_ff;

endmodule

// ----- hdl/puag_checker.sv -----
// Port-level checks of the polar unwrap address generator, bound to the top level.
module puag_checker import puag_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [COORD_W-1:0]  rsp_src_x,
   input logic [COORD_W-1:0]  rsp_src_y,
   input logic [INDEX_W-1:0]  rsp_src_index,
   input logic                rsp_out_of_range
);

   // No result is offered straight after reset.
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result offered after reset");

   // The input side only stalls when a result is held back by the sink.
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_src_x) && $stable(rsp_src_y)
         && $stable(rsp_src_index) && $stable(rsp_out_of_range))
      else $error("stalled result changed");

   // An input offered while ready is low is only held off while a result waits at the output.
   a_req_seen: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

endmodule

bind polar_unwrap_address_generator puag_checker u_puag_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_port.valid),
   .req_ready        (req_port.ready),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_src_x        (rsp_port.src_x),
   .rsp_src_y        (rsp_port.src_y),
   .rsp_src_index    (rsp_port.src_index),
   .rsp_out_of_range (rsp_port.out_of_range)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the polar unwrap address generator.
`timescale 1ns / 100ps

module tb_top;
   import puag_pkg::*;

   // Predicted outcome of one address transaction.
   typedef struct {
      logic [COORD_W-1:0] src_x;
      logic [COORD_W-1:0] src_y;
      logic [INDEX_W-1:0] src_index;
      logic               out_of_range;
   } address_type;

   // Holds its own copy of the registers and the quarter-wave sine table, works out the
   // source address of every accepted request and compares it with the returned address.
   class address_scoreboard;
      longint unsigned sine_rom[1024];
      logic [31:0]       centre;
      logic [DIAM_W-1:0] inner_diam, outer_diam;
      logic [15:0]       phase_offset, gain;
      logic [DIM_W-1:0]  strip_width, cols_reg, rows_reg;
      address_type       awaited[$];
      int                errors;
      int                checked;

      function new();
         longint unsigned x, term, val;
         longint          sum;
         for (int k = 0; k < 1024; k++) begin
            x = (64'd3373259426 * (2 * k + 1)) / 4096;
            term = x;
            sum = x;
            for (int n = 1; n <= 5; n++) begin
               term = (term * x) >> 30;
               term = ((term * x) >> 30) / ((2 * n) * (2 * n + 1));
               if (n % 2 == 1) sum -= term;
               else sum += term;
            end
            if (sum < 0) sum = 0;
            val = (sum + 8192) >> 14;
            sine_rom[k] = (val > 65535) ? 65535 : val;
         end
         centre = RST_CENTRE_PACKED;
         inner_diam = RST_MIN_DIAMETER;
         outer_diam = RST_MAX_DIAMETER;
         phase_offset = RST_ANGLE_OFFSET;
         gain = RST_ASPECT;
         strip_width = RST_OUT_WIDTH;
         cols_reg = RST_SOURCE_COLS;
         rows_reg = RST_SOURCE_ROWS;
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_CENTRE_PACKED: centre = value;
            CSR_MIN_DIAMETER:  inner_diam = value[DIAM_W-1:0];
            CSR_MAX_DIAMETER:  outer_diam = value[DIAM_W-1:0];
            CSR_ANGLE_OFFSET:  phase_offset = value[15:0];
            CSR_ASPECT:        gain = value[15:0];
            CSR_OUT_WIDTH:     strip_width = value[DIM_W-1:0];
            CSR_SOURCE_COLS:   cols_reg = value[DIM_W-1:0];
            CSR_SOURCE_ROWS:   rows_reg = value[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      function longint signed_sine(logic [15:0] p);
         longint unsigned k;
         k = (longint'(p[13:0]) * 1024) >> 14;
         if (p[14]) k = 1023 - k;
         return p[15] ? -longint'(sine_rom[k]) : longint'(sine_rom[k]);
      endfunction

      function void note_request(logic [RING_W-1:0] ring_in, logic [COL_W-1:0] col_in);
         longint unsigned w, h, f, a, step, ring;
         longint          radius, s, c, u, vp, x, y, cols, rows;
         logic [15:0]     phase;
         address_type     res;
         ring = ring_in;
         w = (strip_width > 4096) ? 4096 : strip_width;
         h = (w * 64'd683565276) >> 32;
         f = 0;
         step = 0;
         // A ring past the end of the strip is taken as the outermost one.
         if (h > 0) begin
            if (ring >= h) ring = h - 1;
            f = (ring << 16) / h;
         end
         a = inner_diam * (65536 - f) + outer_diam * f;
         radius = a >> 17;
         if (w > 0) step = (longint'(col_in) << 16) / w;
         phase = step[15:0] + phase_offset;
         s = signed_sine(phase);
         c = signed_sine(phase + QUARTER_TURN);
         u = longint'(centre[31:16]) + ((longint'(gain) * s * radius) >>> 28);
         vp = longint'(centre[15:0]) - ((c * radius) >>> 16);
         cols = (cols_reg > 4096) ? 4096 : cols_reg;
         rows = (rows_reg > 4096) ? 4096 : rows_reg;
         if (cols < 1) cols = 1;
         if (rows < 1) rows = 1;
         x = (vp * cols) >>> 16;
         y = ((65536 - u) * rows) >>> 16;
         res.out_of_range = 1'b0;
         if (x < 0) begin x = 0; res.out_of_range = 1'b1; end
         if (x > cols - 1) begin x = cols - 1; res.out_of_range = 1'b1; end
         if (y < 0) begin y = 0; res.out_of_range = 1'b1; end
         if (y > rows - 1) begin y = rows - 1; res.out_of_range = 1'b1; end
         res.src_x = x[COORD_W-1:0];
         res.src_y = y[COORD_W-1:0];
         res.src_index = INDEX_W'(y * cols + x);
         awaited.push_back(res);
      endfunction

      function void check_address(address_type got);
         address_type want;
         checked++;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected address x=%0d y=%0d index=%0d oor=%0d", $time,
                     got.src_x, got.src_y, got.src_index, got.out_of_range);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.src_x !== want.src_x) begin
            $display("%0t: src_x expected %0d actual %0d", $time, want.src_x, got.src_x);
            errors++;
         end
         if (got.src_y !== want.src_y) begin
            $display("%0t: src_y expected %0d actual %0d", $time, want.src_y, got.src_y);
            errors++;
         end
         if (got.src_index !== want.src_index) begin
            $display("%0t: src_index expected %0d actual %0d", $time, want.src_index,
                     got.src_index);
            errors++;
         end
         if (got.out_of_range !== want.out_of_range) begin
            $display("%0t: out_of_range expected %0d actual %0d", $time, want.out_of_range,
                     got.out_of_range);
            errors++;
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 3000;
   // Settling time after a drain, longer than the depth of the pipeline.
   localparam int SETTLE_CYCLES  = 45;
   localparam int PHASES         = 9;
   localparam int ITEMS_PER_PHASE = 210;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   puag_req_if req_if ();
   puag_rsp_if rsp_if ();

   address_scoreboard addr_sb;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  sent_count;
   int  quiet_cycles;

   polar_unwrap_address_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_if.sink),
      .rsp_port         (rsp_if.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // The clock runs with a 12 ns period.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // The result side stalls at random at the rate set for the current phase.
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Both channels are observed at the clock edge, so that every accepted request is
   // predicted and every accepted result is checked against the oldest prediction. The
   // watchdog counts cycles in which neither side completes a transaction.
   always @(posedge clock) begin
      address_type got;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            addr_sb.note_request(req_if.ring_index, req_if.out_col);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.src_x = rsp_if.src_x;
            got.src_y = rsp_if.src_y;
            got.src_index = rsp_if.src_index;
            got.out_of_range = rsp_if.out_of_range;
            addr_sb.check_address(got);
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Presents one request, idling beforehand at the sender's rate, and returns once the
   // transaction has been accepted. Valid stays high for a following request.
   task automatic send_request(input logic [RING_W-1:0] ring, input logic [COL_W-1:0] col);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.ring_index <= ring;
      req_if.out_col <= col;
      do @(posedge clock); while (!req_if.ready);
      sent_count++;
   endtask

   // Waits until every predicted address has come back and the pipeline is empty.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (addr_sb.awaited.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      addr_sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   // Loads a full register setting. Phases 1 to 4 visit the degenerate low corner (no
   // width, no rings, a one-pixel source), the saturated high corner (oversized width and
   // source) and two narrow strips; the rest are random but sensible.
   task automatic load_setting(input int phase);
      logic [31:0] vals[8];
      case (phase)
         1: vals = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
         2: vals = '{32'hFFFF_FFFF, 32'h1_FFFF, 32'h1_FFFF, 32'hFFFF, 32'hFFFF,
                     32'h1FFF, 32'h1FFF, 32'd4096};
         3: vals = '{32'h8000_8000, 32'd8192, 32'd65536, 32'd16384, 32'd4096,
                     32'd7, 32'd1, 32'd4096};
         4: vals = '{32'h4000_C000, 32'd0, 32'h1_FFFF, 32'h8000, 32'd8192,
                     32'd6, 32'd4096, 32'd1};
         default: begin
            vals[0] = $urandom();
            vals[1] = $urandom_range(0, 131071);
            vals[2] = $urandom_range(0, 131071);
            vals[3] = $urandom_range(0, 65535);
            vals[4] = $urandom_range(0, 65535);
            vals[5] = $urandom_range(7, 4096);
            vals[6] = $urandom_range(1, 4096);
            vals[7] = $urandom_range(1, 4096);
         end
      endcase
      for (int i = 0; i < 8; i++) write_reg(csr_index_type'(i), vals[i]);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [RING_W-1:0] ring;
      logic [COL_W-1:0]  col;
      int                rings;
      addr_sb = new();
      send_idle_pct = 11;
      recv_idle_pct = 81;
      sent_count = 0;
      quiet_cycles = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.ring_index = '0;
      req_if.out_col = '0;
      rsp_if.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests with the reset setting: field extremes, the last ring of the
      // strip and the first past it, each quadrant boundary and single bits set.
      send_request(10'd0, 12'd0);
      send_request(10'd1023, 12'd4095);
      send_request(10'd651, 12'd1024);
      send_request(10'd652, 12'd2048);
      send_request(10'd650, 12'd3072);
      send_request(10'd325, 12'd1023);
      send_request(10'd512, 12'd2047);
      send_request(10'd0, 12'd3071);
      send_request(10'h155, 12'hAAA);
      send_request(10'h2AA, 12'h555);
      send_request(10'd1, 12'd1);
      send_request(10'd1023, 12'd0);
      send_request(10'd0, 12'd4095);
      send_request(10'd100, 12'd512);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         if (phase > 0) load_setting(phase);
         // Idling pattern: sender light and receiver heavy, then swapped, then none.
         if (phase < 3) begin
            send_idle_pct = 11;
            recv_idle_pct = 81;
         end else if (phase < 6) begin
            send_idle_pct = 81;
            recv_idle_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         rings = int'((((addr_sb.strip_width > 4096) ? 4096 : addr_sb.strip_width)
                  * 64'd683565276) >> 32);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // Mostly rings inside the strip; the rest roam the whole field.
            if (rings > 0 && $urandom_range(0, 3) != 0) begin
               ring = RING_W'($urandom_range(0, rings - 1));
            end else begin
               ring = RING_W'($urandom_range(0, 1023));
            end
            col = COL_W'($urandom_range(0, 4095));
            send_request(ring, col);
         end
      end
      drain();

      $display("Covered %0d requests and %0d checked addresses over %0d register settings,",
               sent_count, addr_sb.checked, PHASES);
      $display("with reset, degenerate and saturated corners and three stall patterns.");
      if (addr_sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- polar_unwrap_address_generator.f -----
hdl/puag_pkg.sv
hdl/puag_channels.sv
hdl/puag_div_pipe.sv
hdl/puag_sine_rom.sv
hdl/polar_unwrap_address_generator.sv
hdl/puag_checker.sv
dv/tb_top.sv
